[rtl/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is asserted
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bilge pump checker: assertion failed");

// Concurrent assertion that also holds through reset
`define BPC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bilge pump checker: assertion failed");

`endif

[rtl/bpc_pkg.sv]
// Types, register indexes and reset values for the bilge pump controller
package bpc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MANUAL_OFF     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_OFF       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALARM_OFF      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CYCLIC_RUN     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CYCLIC_IVL     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MANUAL_DEB     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FLOAT_DEB      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_SEC  = 3'd7;

  // Reset values
  localparam logic [7:0]  RST_MANUAL_OFF    = 8'd1;
  localparam logic [7:0]  RST_AUTO_OFF      = 8'd30;
  localparam logic [7:0]  RST_ALARM_OFF     = 8'd120;
  localparam logic [7:0]  RST_CYCLIC_RUN    = 8'd30;
  localparam logic [31:0] RST_CYCLIC_IVL    = 32'd7200000;
  localparam logic [7:0]  RST_MANUAL_DEB    = 8'd100;
  localparam logic [7:0]  RST_FLOAT_DEB     = 8'd50;
  localparam logic [9:0]  RST_TICKS_PER_SEC = 10'd1000;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_MANUAL = 3'd1,
    MODE_AUTO   = 3'd2,
    MODE_HIGH   = 3'd3,
    MODE_DELAY  = 3'd4,
    MODE_CYCLIC = 3'd5
  } mode_e;

  typedef struct packed {
    logic [7:0]  manual_off_s;
    logic [7:0]  auto_off_s;
    logic [7:0]  alarm_off_s;
    logic [7:0]  cyclic_run_s;
    logic [31:0] cyclic_ivl_ms;
    logic [7:0]  manual_deb_ms;
    logic [7:0]  float_deb_ms;
    logic [9:0]  ticks_per_sec;
  } cfg_t;

  // Debounced switch states
  typedef struct packed {
    logic high;
    logic manual;
    logic main;
  } act_t;

endpackage

[rtl/bpc_cfg_regs.sv]
// Configuration register file for the bilge pump controller
module bpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bpc_pkg::cfg_t                 cfg_o
);

  bpc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_off_s  <= bpc_pkg::RST_MANUAL_OFF;
      cfg_q.auto_off_s    <= bpc_pkg::RST_AUTO_OFF;
      cfg_q.alarm_off_s   <= bpc_pkg::RST_ALARM_OFF;
      cfg_q.cyclic_run_s  <= bpc_pkg::RST_CYCLIC_RUN;
      cfg_q.cyclic_ivl_ms <= bpc_pkg::RST_CYCLIC_IVL;
      cfg_q.manual_deb_ms <= bpc_pkg::RST_MANUAL_DEB;
      cfg_q.float_deb_ms  <= bpc_pkg::RST_FLOAT_DEB;
      cfg_q.ticks_per_sec <= bpc_pkg::RST_TICKS_PER_SEC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::CFG_MANUAL_OFF:    cfg_q.manual_off_s  <= cfg_wdata_i[7:0];
        bpc_pkg::CFG_AUTO_OFF:      cfg_q.auto_off_s    <= cfg_wdata_i[7:0];
        bpc_pkg::CFG_ALARM_OFF:     cfg_q.alarm_off_s   <= cfg_wdata_i[7:0];
        bpc_pkg::CFG_CYCLIC_RUN:    cfg_q.cyclic_run_s  <= cfg_wdata_i[7:0];
        bpc_pkg::CFG_CYCLIC_IVL:    cfg_q.cyclic_ivl_ms <= cfg_wdata_i[31:0];
        bpc_pkg::CFG_MANUAL_DEB:    cfg_q.manual_deb_ms <= cfg_wdata_i[7:0];
        bpc_pkg::CFG_FLOAT_DEB:     cfg_q.float_deb_ms  <= cfg_wdata_i[7:0];
        bpc_pkg::CFG_TICKS_PER_SEC: cfg_q.ticks_per_sec <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/bpc_debounce.sv]
// Debounce counters for the main float, high-water float and manual switches
module bpc_debounce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          main_n_i,
  input  logic          high_n_i,
  input  logic          manual_n_i,
  input  bpc_pkg::cfg_t cfg_i,
  output bpc_pkg::act_t act_o
);

  // Index 0 main float, 1 high float, 2 manual
  logic [7:0] cnt_q [3];
  logic [7:0] cnt_d [3];
  logic [2:0] lvl_n;
  logic [7:0] hold  [3];
  logic [2:0] act;

  assign lvl_n   = {manual_n_i, high_n_i, main_n_i};
  assign hold[0] = cfg_i.float_deb_ms;
  assign hold[1] = cfg_i.float_deb_ms;
  assign hold[2] = cfg_i.manual_deb_ms;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lvl_n[i]) begin
        cnt_d[i] = 8'd0;
        act[i]   = 1'b0;
      end else begin
        // saturate at full scale
        cnt_d[i] = (cnt_q[i] == 8'hFF) ? cnt_q[i] : cnt_q[i] + 8'd1;
        act[i]   = (cnt_d[i] >= hold[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) cnt_q[i] <= 8'd0;
    end else if (step_i) begin
      for (int i = 0; i < 3; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  assign act_o.main   = act[0];
  assign act_o.high   = act[1];
  assign act_o.manual = act[2];

endmodule

[rtl/bpc_core.sv]
// Mode selection, off-delay countdown and cyclic run timing
module bpc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  bpc_pkg::act_t  act_i,
  input  bpc_pkg::cfg_t  cfg_i,
  output bpc_pkg::mode_e mode_o
);

  bpc_pkg::mode_e prior_q;
  bpc_pkg::mode_e mode_d;
  logic [7:0]  secs_q, secs_d;
  logic [9:0]  sub_q, sub_d;
  logic        pend_q, pend_d;
  logic [31:0] ms_q, ms_d;

  logic [7:0]  delay_s;
  logic [9:0]  sub_inc;
  logic [7:0]  secs_dec;

  always_comb begin
    unique case (prior_q)
      bpc_pkg::MODE_HIGH:   delay_s = cfg_i.alarm_off_s;
      bpc_pkg::MODE_MANUAL: delay_s = cfg_i.manual_off_s;
      default:              delay_s = cfg_i.auto_off_s;
    endcase
  end

  assign sub_inc  = sub_q + 10'd1;
  assign secs_dec = (secs_q != 8'd0) ? secs_q - 8'd1 : 8'd0;

  always_comb begin
    mode_d = bpc_pkg::MODE_IDLE;
    secs_d = secs_q;
    sub_d  = sub_q;
    pend_d = pend_q;
    ms_d   = ms_q;
    if (act_i.high || act_i.manual || act_i.main) begin
      if (act_i.high)        mode_d = bpc_pkg::MODE_HIGH;
      else if (act_i.manual) mode_d = bpc_pkg::MODE_MANUAL;
      else                   mode_d = bpc_pkg::MODE_AUTO;
      pend_d = 1'b0;
      secs_d = 8'd0;
      sub_d  = 10'd0;
      ms_d   = 32'd0;
    end else if (prior_q == bpc_pkg::MODE_HIGH || prior_q == bpc_pkg::MODE_MANUAL ||
                 prior_q == bpc_pkg::MODE_AUTO) begin
      // source released: load its run-on time
      sub_d = 10'd0;
      if (delay_s == 8'd0) begin
        pend_d = 1'b0;
        secs_d = 8'd0;
        ms_d   = 32'd0;
      end else begin
        pend_d = 1'b1;
        secs_d = delay_s;
        mode_d = bpc_pkg::MODE_DELAY;
      end
    end else if (pend_q) begin
      mode_d = (prior_q == bpc_pkg::MODE_CYCLIC) ? bpc_pkg::MODE_CYCLIC
                                                 : bpc_pkg::MODE_DELAY;
      if (sub_inc >= cfg_i.ticks_per_sec) begin
        sub_d  = 10'd0;
        secs_d = secs_dec;
        if (secs_dec == 8'd0) begin
          pend_d = 1'b0;
          ms_d   = 32'd0;
          mode_d = bpc_pkg::MODE_IDLE;
        end
      end else begin
        sub_d = sub_inc;
      end
    end else if (ms_q > cfg_i.cyclic_ivl_ms) begin
      sub_d = 10'd0;
      if (cfg_i.cyclic_run_s == 8'd0) begin
        pend_d = 1'b0;
        secs_d = 8'd0;
        ms_d   = 32'd0;
      end else begin
        pend_d = 1'b1;
        secs_d = cfg_i.cyclic_run_s;
        mode_d = bpc_pkg::MODE_CYCLIC;
      end
    end else begin
      // hold at full scale
      ms_d = (ms_q == 32'hFFFF_FFFF) ? ms_q : ms_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= bpc_pkg::MODE_IDLE;
      secs_q  <= 8'd0;
      sub_q   <= 10'd0;
      pend_q  <= 1'b0;
      ms_q    <= 32'd0;
    end else if (step_i) begin
      prior_q <= mode_d;
      secs_q  <= secs_d;
      sub_q   <= sub_d;
      pend_q  <= pend_d;
      ms_q    <= ms_d;
    end
  end

  assign mode_o = mode_d;

endmodule

[rtl/bilge_pump_controller_top.sv]
// Bilge pump controller: one request per millisecond tick, one result each
//
// Input channel: in_valid_i / in_stall_o carry one tick with the three
// active-low switch levels. Output channel: out_valid_o / out_stall_i carry
// pump_on_o, alarm_on_o and mode_o for that tick, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge; write only while no request is in flight.
// Path: a request accepted at an edge is held in the input register, and
// its result is loaded into the output register when the output side is free.
// Throughput: one request per cycle while the output is not stalled; the
// debounce, mode and countdown update is a single pass of logic between the
// input and output registers.
// A stall on the output holds the result; the input register still takes a
// request, and in_stall_o rises only when both registers are full.
// Reset clears all switch counters, the countdown and elapsed time, sets the
// mode to idle, loads the register defaults and empties both registers.
module bilge_pump_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          main_float_n_i,
  input  logic                          high_float_n_i,
  input  logic                          manual_n_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pump_on_o,
  output logic                          alarm_on_o,
  output logic [2:0]                    mode_o,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  bpc_pkg::cfg_t  cfg;
  bpc_pkg::act_t  act;
  bpc_pkg::mode_e mode;

  logic in_vld_q, in_vld_d;
  logic main_n_q, high_n_q, manual_n_q;
  logic out_vld_q, out_vld_d;
  logic pump_q, alarm_q;
  logic [2:0] mode_q;
  logic step, in_acc;

  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !step);
  assign out_vld_d  = step || (out_vld_q && out_stall_i);

  bpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bpc_debounce u_deb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .main_n_i  (main_n_q),
    .high_n_i  (high_n_q),
    .manual_n_i(manual_n_q),
    .cfg_i     (cfg),
    .act_o     (act)
  );

  bpc_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .act_i (act),
    .cfg_i (cfg),
    .mode_o(mode)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      main_n_q   <= main_float_n_i;
      high_n_q   <= high_float_n_i;
      manual_n_q <= manual_n_i;
    end
    if (step) begin
      pump_q  <= (mode != bpc_pkg::MODE_IDLE);
      alarm_q <= (mode == bpc_pkg::MODE_HIGH);
      mode_q  <= mode;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pump_on_o   = pump_q;
  assign alarm_on_o  = alarm_q;
  assign mode_o      = mode_q;

endmodule

[rtl/bpc_checker.sv]
// Port-level checks for the bilge pump controller and their binding
`include "assert_macros.svh"

module bpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       pump_on_o,
  input logic       alarm_on_o,
  input logic [2:0] mode_o
);

  // Input side stalls only when the output holds a stalled result
  `BPC_ASSERT(a_stall_backs_up, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)

  // A stalled result holds
  `BPC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) && $stable(pump_on_o))

  // The alarm sounds only in high-water mode with the pump running
  `BPC_ASSERT(a_alarm_high, clk_i, rst_ni, out_valid_o && alarm_on_o |-> pump_on_o && mode_o == bpc_pkg::MODE_HIGH)

  // Nothing is offered straight out of reset
  `BPC_ASSERT_NR(a_reset_empty, clk_i, $rose(rst_ni) |-> !out_valid_o)

endmodule

bind bilge_pump_controller_top bpc_checker u_bpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .pump_on_o  (pump_on_o),
  .alarm_on_o (alarm_on_o),
  .mode_o     (mode_o)
);
